// ===== sv/medf_pkg.sv =====
package medf_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int WIN_SIZE   = 9;
    localparam int PIX_W      = 8;
    localparam int POS_W      = 7;
    localparam int DIM_W      = 8;
    localparam int WIN_IDX_W  = 4;

    // mid queue between the window front and the median back
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_CNT_W    = 3;

    // result queue at the output
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = 2;
    localparam int OUT_CNT_W  = 3;

    localparam logic [DIM_W-1:0] DIM_RESET  = DIM_W'(100);
    localparam logic [DIM_W-1:0] DIM_MIN    = DIM_W'(3);
    localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef logic [WIN_SIZE-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic [POS_W-1:0] crow;
        logic [POS_W-1:0] ccol;
        logic             done;
    } t_tag;

    typedef struct packed {
        t_win win;
        t_tag tag;
    } t_win_item;

    typedef struct packed {
        logic [PIX_W-1:0] median;
        t_tag             tag;
    } t_res;

    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                   logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_MIN) begin
            r = DIM_MIN;
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

    // compare-exchange: min to a, max to b
    function automatic t_win cx(t_win w, logic [WIN_IDX_W-1:0] a,
                                logic [WIN_IDX_W-1:0] b);
        t_win r;
        r = w;
        if (w[a] > w[b]) begin
            r[a] = w[b];
            r[b] = w[a];
        end
        return r;
    endfunction

    // median network, first part: sort each row
    function automatic t_win med_stage1(t_win w);
        t_win r;
        r = w;
        r = cx(r, 4'd1, 4'd2);
        r = cx(r, 4'd4, 4'd5);
        r = cx(r, 4'd7, 4'd8);
        r = cx(r, 4'd0, 4'd1);
        r = cx(r, 4'd3, 4'd4);
        r = cx(r, 4'd6, 4'd7);
        r = cx(r, 4'd1, 4'd2);
        r = cx(r, 4'd4, 4'd5);
        r = cx(r, 4'd7, 4'd8);
        return r;
    endfunction

    function automatic t_win med_stage2(t_win w);
        t_win r;
        r = w;
        r = cx(r, 4'd0, 4'd3);
        r = cx(r, 4'd5, 4'd8);
        r = cx(r, 4'd4, 4'd7);
        r = cx(r, 4'd3, 4'd6);
        r = cx(r, 4'd1, 4'd4);
        r = cx(r, 4'd2, 4'd5);
        r = cx(r, 4'd4, 4'd7);
        return r;
    endfunction

    // median ends up in entry 4
    function automatic t_win med_stage3(t_win w);
        t_win r;
        r = w;
        r = cx(r, 4'd4, 4'd2);
        r = cx(r, 4'd6, 4'd4);
        r = cx(r, 4'd4, 4'd2);
        return r;
    endfunction

endpackage

// ===== sv/median_filter_3x3_unit.sv =====
// Path: a pixel that completes a window passes the line store read registers,
// the window shift into the mid queue, then three median network stages.
// Throughput: one pixel per cycle while full is low; full holds off input when
// the mid queue is near full. The nine-input median network is fully pipelined.
// Reset: synchronous, active low; clears counters, window and queues and sets
// width and height to 100. Line stores are not cleared.
module median_filter_3x3_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // pixel input queue
    input  logic                           push,
    output logic                           full,
    input  logic [medf_pkg::PIX_W-1:0]     i_pixel,
    // result output queue
    output logic                           empty,
    input  logic                           pop,
    output logic [medf_pkg::PIX_W-1:0]     o_median,
    output logic [medf_pkg::POS_W-1:0]     o_center_row,
    output logic [medf_pkg::POS_W-1:0]     o_center_col,
    output logic                           o_frame_done,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  medf_pkg::t_cfg_idx             i_cfg_index,
    input  logic [medf_pkg::DIM_W-1:0]     i_cfg_data
);
    import medf_pkg::*;

    logic [DIM_W-1:0]   r_cfg_width;
    logic [DIM_W-1:0]   r_cfg_height;
    logic [DIM_W-1:0]   width_eff;
    logic [DIM_W-1:0]   height_eff;

    logic               acc;
    logic               q_push;
    logic               q_pop;
    logic               q_empty;
    logic [Q_CNT_W-1:0] q_cnt;
    t_win_item          q_in;
    t_win_item          q_out;
    t_res               res;

    // Configuration: always ready; write only while the block is idle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= DIM_RESET;
            r_cfg_height <= DIM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WIDTH: begin
                    r_cfg_width <= i_cfg_data;
                end
                CFG_HEIGHT: begin
                    r_cfg_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp register values to the supported frame size.
    assign width_eff  = clamp_dim(r_cfg_width, WIDTH_MAX);
    assign height_eff = clamp_dim(r_cfg_height, HEIGHT_MAX);

    // A pixel transfer happens on push while not full.
    assign acc = push && !full;

    // Front: raster counters, line stores and the 3x3 window. Hold off input
    // when the mid queue could not take the window now in flight.
    medf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (acc),
        .i_pixel  (i_pixel),
        .i_width  (width_eff),
        .i_height (height_eff),
        .i_q_cnt  (q_cnt),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_item (q_in)
    );

    // Mid queue: decouple window generation from the median pipeline.
    medf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_empty (q_empty),
        .o_cnt   (q_cnt)
    );

    // Back: median network and output queue; advance only on credit.
    medf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_item  (q_out),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_median     = res.median;
    assign o_center_row = res.tag.crow;
    assign o_center_col = res.tag.ccol;
    assign o_frame_done = res.tag.done;

`ifndef ASSERT_OFF
    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_cnt != Q_CNT_W'(Q_DEPTH)) || q_pop)
        else $error("mid queue overflow");

    a_q_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("mid queue underflow");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");
`endif

endmodule

// ===== sv/medf_front.sv =====
module medf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_acc,
    input  logic [medf_pkg::PIX_W-1:0]    i_pixel,
    input  logic [medf_pkg::DIM_W-1:0]    i_width,
    input  logic [medf_pkg::DIM_W-1:0]    i_height,
    input  logic [medf_pkg::Q_CNT_W-1:0]  i_q_cnt,
    output logic                          o_full,
    output logic                          o_q_push,
    output medf_pkg::t_win_item           o_q_item
);
    import medf_pkg::*;

    logic [PIX_W-1:0] r_mem_up  [MAX_WIDTH];
    logic [PIX_W-1:0] r_mem_mid [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_up;
    logic [PIX_W-1:0] r_rd_mid;

    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;

    logic             r_s1_v;
    logic             r_s1_emit;
    logic [PIX_W-1:0] r_s1_px;
    logic [POS_W-1:0] r_s1_col;
    t_tag             r_s1_tag;

    t_win             r_win, n_win;

    logic [DIM_W-1:0] col_inc, row_inc;
    logic             emit, done;
    logic [Q_CNT_W:0] used;

    // line stores: read old entries, write new pixel into the middle row
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_rd_up          <= r_mem_up[r_col];
            r_rd_mid         <= r_mem_mid[r_col];
            r_mem_mid[r_col] <= i_pixel;
        end
        if (r_s1_v) begin
            r_mem_up[r_s1_col] <= r_rd_mid;
        end
    end

    always_comb begin
        col_inc = {1'b0, r_col} + DIM_W'(1);
        row_inc = {1'b0, r_row} + DIM_W'(1);
        n_col   = r_col;
        n_row   = r_row;
        if (col_inc >= i_width) begin
            n_col = '0;
            n_row = (row_inc >= i_height) ? '0 : row_inc[POS_W-1:0];
        end else begin
            n_col = col_inc[POS_W-1:0];
        end
        emit = (r_row >= POS_W'(2)) && (r_col >= POS_W'(2));
        done = ({1'b0, r_row} == i_height - DIM_W'(1))
            && ({1'b0, r_col} == i_width - DIM_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_s1_v    <= 1'b0;
            r_s1_emit <= 1'b0;
        end else begin
            r_s1_v    <= i_acc;
            r_s1_emit <= i_acc && emit;
            if (i_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_px       <= i_pixel;
            r_s1_col      <= r_col;
            r_s1_tag.crow <= r_row - POS_W'(1);
            r_s1_tag.ccol <= r_col - POS_W'(1);
            r_s1_tag.done <= done;
        end
    end

    // shift the window left, load the new column
    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = r_rd_up;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = r_rd_mid;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_v) begin
            r_win <= n_win;
        end
    end

    assign o_q_push     = r_s1_v && r_s1_emit;
    assign o_q_item.win = n_win;
    assign o_q_item.tag = r_s1_tag;

    assign used   = {1'b0, i_q_cnt} + {{Q_CNT_W{1'b0}}, o_q_push};
    assign o_full = used >= (Q_CNT_W + 1)'(Q_DEPTH);

endmodule

// ===== sv/medf_queue.sv =====
module medf_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  medf_pkg::t_win_item           i_item,
    input  logic                          i_pop,
    output medf_pkg::t_win_item           o_item,
    output logic                          o_empty,
    output logic [medf_pkg::Q_CNT_W-1:0]  o_cnt
);
    import medf_pkg::*;

    t_win_item          r_buf [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_PTR_W'(1);
            end
            r_cnt <= r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    assign o_item  = r_buf[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_cnt   = r_cnt;

endmodule

// ===== sv/medf_back.sv =====
module medf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  medf_pkg::t_win_item           i_q_item,
    output logic                          o_q_pop,
    input  logic                          i_pop,
    output logic                          o_empty,
    output medf_pkg::t_res                o_res
);
    import medf_pkg::*;

    logic                 r_v1, r_v2;
    t_win                 r_w1, r_w2;
    t_tag                 r_t1, r_t2;
    t_win                 sorted;

    t_res                 r_oq [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wp, r_rp;
    logic [OUT_CNT_W-1:0] r_cnt;
    logic [OUT_CNT_W:0]   committed;
    logic                 pop_out;

    // take an item only when the output queue has room for all in flight
    assign committed = {1'b0, r_cnt} + (OUT_CNT_W + 1)'(r_v1)
                     + (OUT_CNT_W + 1)'(r_v2);
    assign o_q_pop   = !i_q_empty && (committed < (OUT_CNT_W + 1)'(OUT_DEPTH));
    assign pop_out   = i_pop && !o_empty;
    assign sorted    = med_stage3(r_w2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= o_q_pop;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w1 <= med_stage1(i_q_item.win);
        r_t1 <= i_q_item.tag;
        r_w2 <= med_stage2(r_w1);
        r_t2 <= r_t1;
        if (r_v2) begin
            r_oq[r_wp].median <= sorted[4];
            r_oq[r_wp].tag    <= r_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_v2) begin
                r_wp <= r_wp + OUT_PTR_W'(1);
            end
            if (pop_out) begin
                r_rp <= r_rp + OUT_PTR_W'(1);
            end
            r_cnt <= r_cnt + OUT_CNT_W'(r_v2) - OUT_CNT_W'(pop_out);
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_res   = r_oq[r_rp];

endmodule
